@@ hdl/imh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the indexed min-heap.
package imh_pkg;

    localparam int KEY_W          = 31;
    localparam int VERT_W         = 8;
    localparam int CFG_W          = 9;
    localparam int MAX_VERTICES_DEF = 256;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(256);

    localparam logic [1:0] FUNC_RESET   = 2'd0;
    localparam logic [1:0] FUNC_SET_KEY = 2'd1;
    localparam logic [1:0] FUNC_REBUILD = 2'd2;
    localparam logic [1:0] FUNC_POP     = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [VERT_W-1:0] vertex;
        logic [KEY_W-1:0]  key;
    } in_t;

    typedef struct packed {
        logic [VERT_W-1:0] popped_vertex;
        logic [KEY_W-1:0]  popped_key;
        logic              pop_valid;
        logic              not_empty;
    } out_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_CLR_STEP,
        DP_SK_RD,
        DP_SK_WR,
        DP_RB_RD,
        DP_RB_LD,
        DP_SIFT_RD,
        DP_SIFT_CMP,
        DP_POP_RD,
        DP_POP_WR,
        DP_DONE
    } dp_op_t;

    typedef struct packed {
        logic clr_last;
        logic live_zero;
        logic live_lt2;
        logic sift_stop;
        logic rb_last;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_BOOT,
        S_IDLE,
        S_CLR,
        S_SK_RD,
        S_SK_WR,
        S_RB_RD,
        S_RB_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_POP_RD,
        S_POP_WR,
        S_DONE
    } state_t;

endpackage

@@ hdl/indexed_min_heap.sv @@
`timescale 1ns / 1ps
// Top level of the indexed min-heap: controller plus datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_ready    | in_data  (func, vertex, key)
//  out      | out_valid / out_ready  | out_data (popped_vertex, popped_key,
//           |                        |           pop_valid, not_empty)
//  cfg      | cfg_wr_en              | cfg_wr_data (active_vertices)
//
// Set key looks up the vertex's slot, then writes its key; reset heap sweeps every slot;
// pop reads the root and last slot, parks the root, then sifts down; rebuild sifts each
// internal node down, from the last to the root. A sift level reads both children through
// the registered read ports of the slot memories, then compares. After rst_n the block
// sweeps all MAX_VERTICES slots before in_ready rises. One operation is in flight at a
// time; a finished result waits in the output register while the next transaction is taken.
module indexed_min_heap #(
    parameter int MAX_VERTICES = imh_pkg::MAX_VERTICES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  imh_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output imh_pkg::out_t             out_data,
    input  logic                      cfg_wr_en,
    input  logic [imh_pkg::CFG_W-1:0] cfg_wr_data
);

    imh_pkg::dp_op_t     op;
    imh_pkg::dp_status_t status;

    imh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (in_data.func),
        .status   (status),
        .in_ready (in_ready),
        .op       (op)
    );

    imh_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .status      (status)
    );

endmodule

@@ hdl/imh_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the indexed min-heap.
module imh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          func,
    input  imh_pkg::dp_status_t status,
    output logic                in_ready,
    output imh_pkg::dp_op_t     op
);

    imh_pkg::state_t state_reg, state_next;
    logic [1:0]      func_reg, func_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imh_pkg::S_BOOT;
            func_reg  <= imh_pkg::FUNC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        op         = imh_pkg::DP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            imh_pkg::S_BOOT:
            begin
                op = imh_pkg::DP_CLR_STEP;
                if (status.clr_last)
                    state_next = imh_pkg::S_IDLE;
            end
            imh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op        = imh_pkg::DP_ACCEPT;
                    func_next = func;
                    unique case (func)
                        imh_pkg::FUNC_RESET:   state_next = imh_pkg::S_CLR;
                        imh_pkg::FUNC_SET_KEY: state_next = imh_pkg::S_SK_RD;
                        imh_pkg::FUNC_REBUILD:
                            state_next = status.live_lt2 ? imh_pkg::S_DONE
                                                         : imh_pkg::S_RB_RD;
                        default:               state_next = imh_pkg::S_POP_RD;
                    endcase
                end
            end
            imh_pkg::S_CLR:
            begin
                op = imh_pkg::DP_CLR_STEP;
                if (status.clr_last)
                    state_next = imh_pkg::S_DONE;
            end
            imh_pkg::S_SK_RD:
            begin
                op         = imh_pkg::DP_SK_RD;
                state_next = imh_pkg::S_SK_WR;
            end
            imh_pkg::S_SK_WR:
            begin
                op         = imh_pkg::DP_SK_WR;
                state_next = imh_pkg::S_DONE;
            end
            imh_pkg::S_RB_RD:
            begin
                op         = imh_pkg::DP_RB_RD;
                state_next = imh_pkg::S_RB_LD;
            end
            imh_pkg::S_RB_LD:
            begin
                op         = imh_pkg::DP_RB_LD;
                state_next = imh_pkg::S_SIFT_RD;
            end
            imh_pkg::S_SIFT_RD:
            begin
                op         = imh_pkg::DP_SIFT_RD;
                state_next = imh_pkg::S_SIFT_CMP;
            end
            imh_pkg::S_SIFT_CMP:
            begin
                op = imh_pkg::DP_SIFT_CMP;
                if (!status.sift_stop)
                    state_next = imh_pkg::S_SIFT_RD;
                else if (func_reg == imh_pkg::FUNC_POP || status.rb_last)
                    state_next = imh_pkg::S_DONE;
                else
                    state_next = imh_pkg::S_RB_RD;
            end
            imh_pkg::S_POP_RD:
            begin
                op         = imh_pkg::DP_POP_RD;
                state_next = imh_pkg::S_POP_WR;
            end
            imh_pkg::S_POP_WR:
            begin
                op         = imh_pkg::DP_POP_WR;
                state_next = status.live_zero ? imh_pkg::S_DONE : imh_pkg::S_SIFT_RD;
            end
            imh_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    op         = imh_pkg::DP_DONE;
                    state_next = imh_pkg::S_IDLE;
                end
            end
            default:
                state_next = imh_pkg::S_IDLE;
        endcase
    end

endmodule

@@ hdl/imh_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the indexed min-heap: slot memories, sift registers, result register.
module imh_dp #(
    parameter int MAX_VERTICES = imh_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  imh_pkg::dp_op_t             op,
    input  imh_pkg::in_t                in_data,
    input  logic                        cfg_wr_en,
    input  logic [imh_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output imh_pkg::out_t               out_data,
    output imh_pkg::dp_status_t         status
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int LW = $clog2(MAX_VERTICES + 1);
    localparam int EW = ((IW > imh_pkg::VERT_W) ? IW : imh_pkg::VERT_W) + 1;
    localparam int AW = ((LW > imh_pkg::CFG_W) ? LW : imh_pkg::CFG_W) + 1;
    localparam int KW = imh_pkg::KEY_W;

    logic [KW-1:0] key_mem [MAX_VERTICES];
    logic [IW-1:0] sv_mem  [MAX_VERTICES];
    logic [IW-1:0] vs_mem  [MAX_VERTICES];

    logic [KW-1:0] key_a_reg, key_b_reg;
    logic [IW-1:0] sv_a_reg, sv_b_reg, vs_a_reg;

    logic [imh_pkg::CFG_W-1:0] active_reg;
    logic [LW-1:0]  live_reg, live_next;
    logic [IW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [IW-1:0]  rb_idx_reg, rb_idx_next;
    logic [IW-1:0]  node_reg, node_next;
    logic [KW-1:0]  mov_key_reg, mov_key_next;
    logic [IW-1:0]  mov_vtx_reg, mov_vtx_next;
    logic           have_l_reg, have_l_next, have_r_reg, have_r_next;
    imh_pkg::in_t   item_reg, item_next;
    logic [imh_pkg::VERT_W-1:0] pv_reg, pv_next;
    logic [KW-1:0]  pk_reg, pk_next;
    logic           pvalid_reg, pvalid_next;
    logic           out_valid_reg, out_valid_next;
    imh_pkg::out_t  out_data_reg, out_data_next;

    logic [IW-1:0]  rd_a_addr, rd_b_addr, vs_rd_addr;
    logic           key_we, sv_we, vs_we;
    logic [IW-1:0]  wr_addr, vs_waddr;
    logic [KW-1:0]  wr_key;
    logic [IW-1:0]  wr_sv, vs_wdata;

    logic [IW+1:0]  left_idx, right_idx, live_ext;
    logic [IW-1:0]  last_slot;
    logic [AW-1:0]  act_ext;
    logic [LW-1:0]  live_cfg;
    logic           vtx_ok;
    logic           pick_l, pick_r;
    logic [KW-1:0]  best_key;

    assign left_idx  = {1'b0, node_reg, 1'b1};
    assign right_idx = (IW + 2)'(left_idx + (IW + 2)'(1));
    assign live_ext  = (IW + 2)'(live_reg);
    assign last_slot = IW'(live_reg - LW'(1));
    assign act_ext   = AW'(active_reg);
    assign live_cfg  = (act_ext > AW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(act_ext);
    assign vtx_ok    = EW'(item_reg.vertex) < EW'(MAX_VERTICES);

    // Strict compare, the left child wins a tie.
    always_comb
    begin
        pick_l   = have_l_reg && (key_a_reg < mov_key_reg);
        best_key = pick_l ? key_a_reg : mov_key_reg;
        pick_r   = have_r_reg && (key_b_reg < best_key);
    end

    assign status.clr_last  = (clr_cnt_reg == IW'(MAX_VERTICES - 1));
    assign status.live_zero = (live_reg == '0);
    assign status.live_lt2  = (live_reg < LW'(2));
    assign status.sift_stop = !(pick_l || pick_r);
    assign status.rb_last   = (rb_idx_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Read ports
    always_comb
    begin
        rd_a_addr  = '0;
        rd_b_addr  = '0;
        vs_rd_addr = IW'(item_reg.vertex);
        case (op)
            imh_pkg::DP_RB_RD:   rd_a_addr = rb_idx_reg;
            imh_pkg::DP_POP_RD:  rd_b_addr = last_slot;
            imh_pkg::DP_SIFT_RD:
            begin
                rd_a_addr = left_idx[IW-1:0];
                rd_b_addr = right_idx[IW-1:0];
            end
            default: ;
        endcase
    end

    // Write ports
    always_comb
    begin
        key_we   = 1'b0;
        sv_we    = 1'b0;
        vs_we    = 1'b0;
        wr_addr  = node_reg;
        wr_key   = mov_key_reg;
        wr_sv    = mov_vtx_reg;
        vs_waddr = mov_vtx_reg;
        vs_wdata = node_reg;
        case (op)
            imh_pkg::DP_CLR_STEP:
            begin
                key_we   = 1'b1;
                sv_we    = 1'b1;
                vs_we    = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_key   = imh_pkg::KEY_MAX;
                wr_sv    = clr_cnt_reg;
                vs_waddr = clr_cnt_reg;
                vs_wdata = clr_cnt_reg;
            end
            imh_pkg::DP_SK_WR:
            begin
                key_we  = vtx_ok;
                wr_addr = vs_a_reg;
                wr_key  = item_reg.key;
            end
            imh_pkg::DP_POP_WR:
            begin
                // park the old root in the last live slot
                key_we   = !status.live_zero;
                sv_we    = !status.live_zero;
                vs_we    = !status.live_zero;
                wr_addr  = last_slot;
                wr_key   = key_a_reg;
                wr_sv    = sv_a_reg;
                vs_waddr = sv_a_reg;
                vs_wdata = last_slot;
            end
            imh_pkg::DP_SIFT_CMP:
            begin
                key_we = 1'b1;
                sv_we  = 1'b1;
                vs_we  = 1'b1;
                if (pick_r)
                begin
                    wr_key   = key_b_reg;
                    wr_sv    = sv_b_reg;
                    vs_waddr = sv_b_reg;
                end
                else if (pick_l)
                begin
                    wr_key   = key_a_reg;
                    wr_sv    = sv_a_reg;
                    vs_waddr = sv_a_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[wr_addr] <= wr_key;
        if (sv_we)
            sv_mem[wr_addr] <= wr_sv;
        if (vs_we)
            vs_mem[vs_waddr] <= vs_wdata;
        key_a_reg <= key_mem[rd_a_addr];
        key_b_reg <= key_mem[rd_b_addr];
        sv_a_reg  <= sv_mem[rd_a_addr];
        sv_b_reg  <= sv_mem[rd_b_addr];
        vs_a_reg  <= vs_mem[vs_rd_addr];
    end

    // Working registers
    always_comb
    begin
        live_next      = live_reg;
        clr_cnt_next   = clr_cnt_reg;
        rb_idx_next    = rb_idx_reg;
        node_next      = node_reg;
        mov_key_next   = mov_key_reg;
        mov_vtx_next   = mov_vtx_reg;
        have_l_next    = have_l_reg;
        have_r_next    = have_r_reg;
        item_next      = item_reg;
        pv_next        = pv_reg;
        pk_next        = pk_reg;
        pvalid_next    = pvalid_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (op)
            imh_pkg::DP_ACCEPT:
            begin
                item_next    = in_data;
                clr_cnt_next = '0;
                rb_idx_next  = IW'((live_reg - LW'(2)) >> 1);
                pv_next      = '0;
                pk_next      = '0;
                pvalid_next  = 1'b0;
            end
            imh_pkg::DP_CLR_STEP:
            begin
                clr_cnt_next = IW'(clr_cnt_reg + IW'(1));
                if (status.clr_last)
                    live_next = live_cfg;
            end
            imh_pkg::DP_RB_LD:
            begin
                node_next    = rb_idx_reg;
                mov_key_next = key_a_reg;
                mov_vtx_next = sv_a_reg;
            end
            imh_pkg::DP_SIFT_RD:
            begin
                have_l_next = left_idx < live_ext;
                have_r_next = right_idx < live_ext;
            end
            imh_pkg::DP_SIFT_CMP:
            begin
                if (pick_r)
                    node_next = right_idx[IW-1:0];
                else if (pick_l)
                    node_next = left_idx[IW-1:0];
                else
                    rb_idx_next = IW'(rb_idx_reg - IW'(1));
            end
            imh_pkg::DP_POP_WR:
            begin
                if (!status.live_zero)
                begin
                    pv_next      = imh_pkg::VERT_W'(sv_a_reg);
                    pk_next      = key_a_reg;
                    pvalid_next  = 1'b1;
                    live_next    = LW'(live_reg - LW'(1));
                    node_next    = '0;
                    mov_key_next = key_b_reg;
                    mov_vtx_next = sv_b_reg;
                end
            end
            imh_pkg::DP_DONE:
            begin
                out_valid_next               = 1'b1;
                out_data_next.popped_vertex  = pv_reg;
                out_data_next.popped_key     = pk_reg;
                out_data_next.pop_valid      = pvalid_reg;
                out_data_next.not_empty      = (live_reg != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= imh_pkg::ACTIVE_RESET;
            live_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                active_reg <= cfg_wr_data;
            live_reg      <= live_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rb_idx_reg   <= rb_idx_next;
        node_reg     <= node_next;
        mov_key_reg  <= mov_key_next;
        mov_vtx_reg  <= mov_vtx_next;
        have_l_reg   <= have_l_next;
        have_r_reg   <= have_r_next;
        item_reg     <= item_next;
        pv_reg       <= pv_next;
        pk_reg       <= pk_next;
        pvalid_reg   <= pvalid_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LW'(MAX_VERTICES))
        else $error("live count above heap size");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (op == imh_pkg::DP_POP_WR && live_reg != '0)
            |=> live_reg == LW'($past(live_reg) - LW'(1)))
        else $error("pop did not shrink the heap by one");

    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == imh_pkg::DP_DONE) |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an untaken transaction");

endmodule

@@ test/tb_indexed_min_heap.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the indexed min-heap: directed, sequence, back-pressure and noise tests.
module tb_indexed_min_heap;

    localparam int NV         = imh_pkg::MAX_VERTICES_DEF;
    localparam int CYCLE_CAP  = 3000000;
    localparam int LONG_HOLD  = 600;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    imh_pkg::in_t              in_data;
    logic                      out_valid;
    logic                      out_ready;
    imh_pkg::out_t             out_data;
    logic                      cfg_wr_en;
    logic [imh_pkg::CFG_W-1:0] cfg_wr_data;

    // Predicted heap state
    logic [imh_pkg::KEY_W-1:0]  heap_key [NV];
    logic [imh_pkg::VERT_W-1:0] heap_vert [NV];
    int                         vert_pos [NV];
    int                         live_cnt;
    int                         active_cfg;

    imh_pkg::out_t pending_pops [$];
    int   err_cnt;
    int   cycle_cnt;
    bit   steady;       // no idling on either side
    int   hold_req;     // receiver long hold-off, in cycles

    indexed_min_heap i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic void swap_slots(int a, int b);
        logic [imh_pkg::KEY_W-1:0]  k;
        logic [imh_pkg::VERT_W-1:0] v;
        k = heap_key[a];
        v = heap_vert[a];
        heap_key[a]  = heap_key[b];
        heap_vert[a] = heap_vert[b];
        heap_key[b]  = k;
        heap_vert[b] = v;
        vert_pos[heap_vert[a]] = a;
        vert_pos[heap_vert[b]] = b;
    endfunction

    function automatic void sift_down(int node);
        int best;
        int lc;
        int rc;
        while (node < live_cnt)
        begin
            best = node;
            lc   = 2 * node + 1;
            rc   = 2 * node + 2;
            if (lc < live_cnt && heap_key[lc] < heap_key[best])
                best = lc;
            if (rc < live_cnt && heap_key[rc] < heap_key[best])
                best = rc;
            if (best == node)
                break;
            swap_slots(node, best);
            node = best;
        end
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < NV; i++)
        begin
            heap_key[i]  = imh_pkg::KEY_MAX;
            heap_vert[i] = imh_pkg::VERT_W'(i);
            vert_pos[i]  = i;
        end
        live_cnt = (active_cfg > NV) ? NV : active_cfg;
    endfunction

    function automatic imh_pkg::out_t heap_step(imh_pkg::in_t op);
        imh_pkg::out_t r;
        r = '0;
        case (op.func)
            imh_pkg::FUNC_RESET:   clear_heap();
            imh_pkg::FUNC_SET_KEY: heap_key[vert_pos[op.vertex]] = op.key;
            imh_pkg::FUNC_REBUILD:
                if (live_cnt >= 2)
                    for (int i = (live_cnt - 2) / 2; i >= 0; i--)
                        sift_down(i);
            default:
                if (live_cnt > 0)
                begin
                    r.popped_vertex = heap_vert[0];
                    r.popped_key    = heap_key[0];
                    r.pop_valid     = 1'b1;
                    live_cnt--;
                    swap_slots(0, live_cnt);
                    sift_down(0);
                end
        endcase
        r.not_empty = (live_cnt > 0);
        return r;
    endfunction

    // ---------------- channels ----------------
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    task automatic send_op(logic [1:0] f, int v, logic [imh_pkg::KEY_W-1:0] k);
        int gap;
        imh_pkg::in_t op;
        gap = steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op.func   = f;
        op.vertex = imh_pkg::VERT_W'(v);
        op.key    = k;
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pops.push_back(heap_step(op));
    endtask

    always
    begin : receiver
        int stall;
        if (rst_n !== 1'b1)
            @(posedge clk);
        else
        begin
            if (hold_req > 0)
            begin
                stall = hold_req;
                hold_req = 0;
            end
            else
                stall = steady ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_pops.size() == 0)
                report("unexpected transaction", out_data, 0);
            else
            begin : compare
                imh_pkg::out_t want;
                want = pending_pops.pop_front();
                if (out_data.popped_vertex !== want.popped_vertex)
                    report("popped_vertex", out_data.popped_vertex, want.popped_vertex);
                if (out_data.popped_key !== want.popped_key)
                    report("popped_key", out_data.popped_key, want.popped_key);
                if (out_data.pop_valid !== want.pop_valid)
                    report("pop_valid", out_data.pop_valid, want.pop_valid);
                if (out_data.not_empty !== want.not_empty)
                    report("not_empty", out_data.not_empty, want.not_empty);
            end
        end
    end

    // Drain, then write the vertex count while the block is idle.
    task automatic write_active(int n);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pops.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= imh_pkg::CFG_W'(n);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        active_cfg = n;
    endtask

    function automatic logic [imh_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return imh_pkg::KEY_MAX;
            2, 3, 4: return imh_pkg::KEY_W'($urandom_range(0, 7));
            default: return imh_pkg::KEY_W'($urandom);
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return NV;
            1, 2:    return $urandom_range(33, 128);
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        send_op(imh_pkg::FUNC_POP, 0, '0);                  // all keys at maximum
        send_op(imh_pkg::FUNC_SET_KEY, 0, '0);
        send_op(imh_pkg::FUNC_SET_KEY, 255, imh_pkg::KEY_MAX);
        send_op(imh_pkg::FUNC_SET_KEY, 170, imh_pkg::KEY_W'(3));
        send_op(imh_pkg::FUNC_SET_KEY, 85, imh_pkg::KEY_W'(3));      // tie
        send_op(imh_pkg::FUNC_SET_KEY, 9, imh_pkg::KEY_W'('h2AAAAAAA));
        send_op(imh_pkg::FUNC_SET_KEY, 1, imh_pkg::KEY_W'('h55555555));
        send_op(imh_pkg::FUNC_REBUILD, 0, '0);
        repeat (4) send_op(imh_pkg::FUNC_POP, 0, '0);
        send_op(imh_pkg::FUNC_SET_KEY, 0, imh_pkg::KEY_W'(1));       // vertex already popped
        write_active(1);
        send_op(imh_pkg::FUNC_RESET, 0, '0);
        send_op(imh_pkg::FUNC_REBUILD, 0, '0);              // fewer than two entries
        send_op(imh_pkg::FUNC_POP, 0, '0);
        send_op(imh_pkg::FUNC_POP, 0, '0);                  // empty heap
        send_op(imh_pkg::FUNC_REBUILD, 0, '0);
        write_active(2);
        send_op(imh_pkg::FUNC_RESET, 0, '0);
        send_op(imh_pkg::FUNC_SET_KEY, 1, imh_pkg::KEY_W'(5));
        send_op(imh_pkg::FUNC_SET_KEY, 0, imh_pkg::KEY_W'(5));
        send_op(imh_pkg::FUNC_REBUILD, 0, '0);
        repeat (3) send_op(imh_pkg::FUNC_POP, 0, '0);
    endtask

    task automatic heap_round(int n);
        int sets;
        write_active(n);
        send_op(imh_pkg::FUNC_RESET, 0, '0);
        sets = $urandom_range(1, (n < 24) ? n + 2 : 24);
        repeat (sets) send_op(imh_pkg::FUNC_SET_KEY, $urandom_range(0, n - 1), pick_key());
        if ($urandom_range(0, 7) == 0)
            send_op(imh_pkg::FUNC_SET_KEY, $urandom_range(0, 255), pick_key());
        send_op(imh_pkg::FUNC_REBUILD, 0, '0);
        repeat ($urandom_range(1, (n < 30 ? n : 30) + 2))
        begin
            send_op(imh_pkg::FUNC_POP, 0, '0);
            // Prim-style key update of a random vertex, then rebuild
            if ($urandom_range(0, 5) == 0)
            begin
                send_op(imh_pkg::FUNC_SET_KEY, $urandom_range(0, n - 1), pick_key());
                send_op(imh_pkg::FUNC_REBUILD, 0, '0);
            end
        end
    endtask

    task automatic test_sequences();
        for (int r = 0; r < 52; r++)
        begin
            steady = (r % 9 == 4);
            heap_round(pick_count());
        end
        steady = 1'b0;
        heap_round(NV);
        heap_round(1);
    endtask

    task automatic test_noise();
        write_active($urandom_range(1, 40));
        repeat (200)
            send_op(2'($urandom_range(0, 3)), $urandom_range(0, 255), pick_key());
    endtask

    task automatic test_backpressure();
        write_active(16);
        send_op(imh_pkg::FUNC_RESET, 0, '0);
        hold_req = LONG_HOLD;
        repeat (40) send_op(imh_pkg::FUNC_POP, 0, '0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        err_cnt     = 0;
        cycle_cnt   = 0;
        steady      = 1'b0;
        hold_req    = 0;
        active_cfg  = NV;
        clear_heap();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sequences();
        test_backpressure();
        test_noise();
        write_active(NV);
        send_op(imh_pkg::FUNC_RESET, 0, '0);
        send_op(imh_pkg::FUNC_POP, 0, '0);

        in_valid <= 1'b0;
        while (pending_pops.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ indexed_min_heap.f @@
hdl/imh_pkg.sv
hdl/imh_ctrl.sv
hdl/imh_dp.sv
hdl/indexed_min_heap.sv
test/tb_indexed_min_heap.sv
